>>> design/rmed_pkg.sv
// Shared transaction types and field widths for the running median block.
package rmed_pkg;

   localparam int FIELD_BITS = 16;
   localparam int FILL_BITS  = 7;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] sample;
      logic                         restart;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] median_floor;
      logic                         median_half;
      logic                         overflow;
      logic [FILL_BITS-1:0]         fill_count;
   } rsp_type;

endpackage

>>> design/rmed_cell.sv
// One sorted-store cell: holds a sample and shifts right on an insert below it.
module rmed_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int CNT_BITS    = 7,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  logic                   insert,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [CNT_BITS-1:0]    count,
   input  logic [CNT_BITS-1:0]    lo_idx,
   input  logic [CNT_BITS-1:0]    hi_idx,
   input  logic                   left_gt,
   input  logic [SAMPLE_BITS-1:0] left_value,
   output logic                   gt,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [SAMPLE_BITS-1:0] lo_tap,
   output logic [SAMPLE_BITS-1:0] hi_tap
);

   localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [SAMPLE_BITS-1:0] value_in;
   logic                   live;
   logic                   at_end;
   logic                   write;

   assign live   = count > MY_INDEX;
   assign at_end = count == MY_INDEX;
   assign gt     = live && ($signed(value_ff) > $signed(sample));
   // the first cell above the sample takes it, the rest take their left neighbour
   assign write    = insert && (gt || at_end);
   assign value_in = left_gt ? left_value : sample;

   always_ff @(posedge clock) begin
      if (write) begin
         value_ff <= value_in;
      end
   end

   assign value  = value_ff;
   assign lo_tap = (lo_idx == MY_INDEX) ? value_ff : '0;
   assign hi_tap = (hi_idx == MY_INDEX) ? value_ff : '0;

endmodule

>>> design/rmed_select.sv
// Radix-4 OR fold that picks the two middle samples out of the cell taps.
module rmed_select #(
   parameter int SAMPLE_BITS = 16,
   parameter int CAPACITY    = 64
) (
   input  logic                   clock,
   input  logic                   gather,
   input  logic                   fold,
   input  logic [SAMPLE_BITS-1:0] lo_tap [CAPACITY],
   input  logic [SAMPLE_BITS-1:0] hi_tap [CAPACITY],
   output logic [SAMPLE_BITS-1:0] lo_value,
   output logic [SAMPLE_BITS-1:0] hi_value
);

   localparam int NODES = (CAPACITY + 3) / 4;

   logic [SAMPLE_BITS-1:0] lo_ff [NODES];
   logic [SAMPLE_BITS-1:0] hi_ff [NODES];
   logic [SAMPLE_BITS-1:0] lo_gather [NODES];
   logic [SAMPLE_BITS-1:0] hi_gather [NODES];
   logic [SAMPLE_BITS-1:0] lo_fold [NODES];
   logic [SAMPLE_BITS-1:0] hi_fold [NODES];

   // only one tap per side is non-zero, so OR acts as the select
   for (genvar j = 0; j < NODES; j++) begin : g_node
      always_comb begin
         lo_gather[j] = '0;
         hi_gather[j] = '0;
         lo_fold[j]   = '0;
         hi_fold[j]   = '0;
         for (int k = 0; k < 4; k++) begin
            if (4 * j + k < CAPACITY) begin
               lo_gather[j] = lo_gather[j] | lo_tap[4*j+k];
               hi_gather[j] = hi_gather[j] | hi_tap[4*j+k];
            end
            // nodes past the live range read zero, so the array cleans itself
            if (4 * j + k < NODES) begin
               lo_fold[j] = lo_fold[j] | lo_ff[4*j+k];
               hi_fold[j] = hi_fold[j] | hi_ff[4*j+k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (gather) begin
            lo_ff[j] <= lo_gather[j];
            hi_ff[j] <= hi_gather[j];
         end else if (fold) begin
            lo_ff[j] <= lo_fold[j];
            hi_ff[j] <= hi_fold[j];
         end
      end
   end

   assign lo_value = lo_ff[0];
   assign hi_value = hi_ff[0];

endmodule

>>> design/running_median_top.sv
// Running median: samples go into a row of CAPACITY sorted insertion cells; each
// transaction inserts one sample (every cell compares against it in parallel
// and shifts right if larger), then the two middle cells are picked by a radix-4
// OR fold and averaged. A transaction steps through the insert in IDLE, GATHER,
// F fold passes in FOLD, where F = ceil(log2(ceil(CAPACITY/4)) / 2), and DONE.
// A finished result waits in the output register while the next sample is
// taken. restart empties the store before the insert; when the store is full
// the sample is dropped and overflow is flagged.
module running_median_top
   import rmed_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int NODES     = (CAPACITY + 3) / 4;
   localparam int FOLDS     = ($clog2(NODES) + 1) / 2;
   localparam int FOLD_BITS = (FOLDS > 1) ? $clog2(FOLDS) : 1;
   localparam int RAW_BITS  = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

   typedef enum logic [1:0] {
      IDLE,
      GATHER,
      FOLD,
      DONE
   } state_type;

   state_type              state_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;
   logic [CNT_BITS-1:0]    count_eff;
   logic                   ovf_ff;
   logic [FOLD_BITS-1:0]   fold_cnt_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic                   req_take;
   logic                   full;
   logic                   insert;
   logic [RAW_BITS-1:0]    raw_sample;
   logic [SAMPLE_BITS-1:0] sample;
   logic [CNT_BITS-1:0]    lo_idx;
   logic [CNT_BITS-1:0]    hi_idx;
   logic                   gather;
   logic                   fold;
   logic                   out_free;

   logic                   gt_w     [CAPACITY];
   logic [SAMPLE_BITS-1:0] value_w  [CAPACITY];
   logic [SAMPLE_BITS-1:0] lo_tap_w [CAPACITY];
   logic [SAMPLE_BITS-1:0] hi_tap_w [CAPACITY];
   logic [SAMPLE_BITS-1:0] lo_value;
   logic [SAMPLE_BITS-1:0] hi_value;
   logic [SAMPLE_BITS:0]   mid_sum;
   logic [RAW_BITS-1:0]    med_wide;

   assign req_stall = (state_ff != IDLE);
   assign req_take  = req_valid && !req_stall;

   // bits above SAMPLE_BITS are ignored; a wider store sees the field unsigned
   assign raw_sample = RAW_BITS'(unsigned'(req_payload.sample));
   assign sample     = raw_sample[SAMPLE_BITS-1:0];

   assign count_eff = req_payload.restart ? '0 : count_ff;
   assign full      = (count_eff == CNT_BITS'(CAPACITY));
   assign insert    = req_take && !full;
   assign count_in  = full ? count_eff : count_eff + CNT_BITS'(1);

   // count is at least one once an item has been taken
   assign lo_idx = (count_ff - CNT_BITS'(1)) >> 1;
   assign hi_idx = count_ff >> 1;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         rmed_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .CNT_BITS   (CNT_BITS),
            .INDEX      (i)
         ) u_cell (
            .clock     (clock),
            .insert    (insert),
            .sample    (sample),
            .count     (count_eff),
            .lo_idx    (lo_idx),
            .hi_idx    (hi_idx),
            .left_gt   (1'b0),
            .left_value('0),
            .gt        (gt_w[i]),
            .value     (value_w[i]),
            .lo_tap    (lo_tap_w[i]),
            .hi_tap    (hi_tap_w[i])
         );
      end else begin : g_rest
         rmed_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .CNT_BITS   (CNT_BITS),
            .INDEX      (i)
         ) u_cell (
            .clock     (clock),
            .insert    (insert),
            .sample    (sample),
            .count     (count_eff),
            .lo_idx    (lo_idx),
            .hi_idx    (hi_idx),
            .left_gt   (gt_w[i-1]),
            .left_value(value_w[i-1]),
            .gt        (gt_w[i]),
            .value     (value_w[i]),
            .lo_tap    (lo_tap_w[i]),
            .hi_tap    (hi_tap_w[i])
         );
      end
   end

   assign gather = (state_ff == GATHER);
   assign fold   = (state_ff == FOLD);

   rmed_select #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .CAPACITY   (CAPACITY)
   ) u_select (
      .clock   (clock),
      .gather  (gather),
      .fold    (fold),
      .lo_tap  (lo_tap_w),
      .hi_tap  (hi_tap_w),
      .lo_value(lo_value),
      .hi_value(hi_value)
   );

   // odd count: both picks are the same cell, so the sum is even
   assign mid_sum  = {lo_value[SAMPLE_BITS-1], lo_value} + {hi_value[SAMPLE_BITS-1], hi_value};
   assign med_wide = RAW_BITS'(mid_sum[SAMPLE_BITS:1]);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         fold_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_take) begin
                  count_ff <= count_in;
                  ovf_ff   <= full;
                  state_ff <= GATHER;
               end
            end
            GATHER: begin
               fold_cnt_ff <= '0;
               state_ff    <= (FOLDS == 0) ? DONE : FOLD;
            end
            FOLD: begin
               fold_cnt_ff <= fold_cnt_ff + FOLD_BITS'(1);
               if (fold_cnt_ff == FOLD_BITS'(FOLDS - 1)) begin
                  state_ff <= DONE;
               end
            end
            DONE: begin
               if (out_free) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == DONE && out_free) begin
         rsp_ff.median_floor <= med_wide[FIELD_BITS-1:0];
         rsp_ff.median_half  <= mid_sum[0];
         rsp_ff.overflow     <= ovf_ff;
         rsp_ff.fill_count   <= FILL_BITS'(count_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> bench/tb_running_median_top.sv
// Self-checking testbench for running_median_top: sorted-store predictor, random stream segments.
module tb_running_median_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rmed_pkg::*;

   localparam int DEPTH       = 64;
   localparam int STREAM_LEN  = 450;
   localparam int CALM_TAIL   = 60;
   localparam int HOLD_CYCLES = 150;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE      = 20;

   // Keeps its own sorted copy of the samples and the median each transaction should give.
   class median_tracker;
      logic signed [FIELD_BITS-1:0] ordered[DEPTH];
      int                           held;
      rsp_type                      pending_medians[$];
      int                           errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      function void note_sample(req_type item);
         rsp_type                    want;
         logic signed [FIELD_BITS:0] pair_sum;
         int                         pos;
         int                         mid;
         if (item.restart)
            held = 0;
         want = '0;
         if (held >= DEPTH) begin
            want.overflow = 1'b1;
         end else begin
            pos = held;
            while (pos > 0 && ordered[pos-1] > item.sample) begin
               ordered[pos] = ordered[pos-1];
               pos--;
            end
            ordered[pos] = item.sample;
            held++;
         end
         mid = held / 2;
         if (held % 2 == 1) begin
            want.median_floor = ordered[mid];
         end else if (held > 0) begin
            pair_sum          = ordered[mid-1] + ordered[mid];
            want.median_half  = pair_sum[0];
            want.median_floor = FIELD_BITS'(pair_sum >>> 1);
         end
         want.fill_count = FILL_BITS'(held);
         pending_medians.push_back(want);
      endfunction

      task report(string what);
         $display("%0t ns: mismatch: %s", $realtime, what);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending_medians.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
         end
         want = pending_medians.pop_front();
         if (got.median_floor !== want.median_floor)
            report($sformatf("median_floor %0d, expected %0d", got.median_floor,
                             want.median_floor));
         if (got.median_half !== want.median_half)
            report($sformatf("median_half %b, expected %b", got.median_half,
                             want.median_half));
         if (got.overflow !== want.overflow)
            report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
         if (got.fill_count !== want.fill_count)
            report($sformatf("fill_count %0d, expected %0d", got.fill_count,
                             want.fill_count));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   median_tracker tracker = new();
   bit            calm;
   bit            hold_wanted;
   int            idle_cycles;
   int            issued;

   running_median_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Accepted transactions on both channels, plus the idle watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_sample(req_payload);
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_payload);
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none once calm.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer(input logic signed [FIELD_BITS-1:0] value, input logic restart_bit);
      req_type item;
      item.sample  = value;
      item.restart = restart_bit;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      issued++;
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // wait on the clock before checking the queue so the monitor has logged the last accepted transaction
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_medians.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic signed [FIELD_BITS-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0: return FIELD_BITS'($urandom_range(0, 8)) - FIELD_BITS'(4);
         1: begin
            case ($urandom_range(0, 5))
               0: return 16'sh8000;
               1: return 16'sh8001;
               2: return 16'sh7fff;
               3: return 16'sh7ffe;
               4: return -16'sd1;
               default: return 16'sd0;
            endcase
         end
         default: return FIELD_BITS'($urandom());
      endcase
   endfunction

   initial begin
      int seg_len;
      int k;
      bit hold_done;
      bit pause_done;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      calm        = 1'b0;
      hold_wanted = 1'b0;
      hold_done   = 1'b0;
      pause_done  = 1'b0;
      idle_cycles = 0;
      issued      = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Extremes, half bit with negative sums, duplicates and restarts
      offer(16'sd0, 1'b1);
      offer(16'sh8000, 1'b0);
      offer(16'sh7fff, 1'b0);
      offer(16'sh7fff, 1'b0);
      offer(-16'sd1, 1'b1);
      offer(16'sd0, 1'b0);
      offer(-16'sd1, 1'b0);
      offer(-16'sd1, 1'b0);
      offer(16'sh7fff, 1'b1);
      offer(16'sh7fff, 1'b0);
      offer(16'sh8000, 1'b1);
      offer(16'sh8000, 1'b0);
      offer(16'sd1, 1'b1);
      offer(-16'sd2, 1'b0);
      offer(16'sd5, 1'b1);
      offer(16'sd4, 1'b0);
      offer(16'sd5, 1'b0);
      offer(-16'sd3, 1'b0);
      drain();

      // Stream segments: each starts with a restart, many run past a full store
      while (issued < STREAM_LEN) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: seg_len = $urandom_range(1, 12);
            4, 5, 6, 7: seg_len = $urandom_range(DEPTH, DEPTH + 12);
            default:    seg_len = $urandom_range(1, DEPTH - 1);
         endcase
         for (k = 0; k < seg_len; k++) begin
            if (issued >= STREAM_LEN - CALM_TAIL)
               calm = 1'b1;
            if (!hold_done && issued >= 120) begin
               hold_done   = 1'b1;
               hold_wanted = 1'b1;
            end
            if (!pause_done && issued >= 250) begin
               pause_done = 1'b1;
               drain();
            end
            // occasional stray restart breaks a segment
            offer(pick_sample(), k == 0 || $urandom_range(0, 49) == 0);
            maybe_gap();
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (tracker.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> sim.f
design/rmed_pkg.sv
design/rmed_cell.sv
design/rmed_select.sv
design/running_median_top.sv
bench/tb_running_median_top.sv
